// ===== src/pbpm_pkg.sv =====
package pbpm_pkg;

  localparam int unsigned SLOTS   = 16;
  localparam int unsigned SlotW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PinW    = 8;
  localparam int unsigned FileW   = 8;
  localparam int unsigned PageW   = 24;
  localparam int unsigned IdxOutW = 4;

  localparam logic [PinW-1:0] PIN_MAX = {PinW{1'b1}};

  typedef enum logic [2:0] {
    CMD_PIN   = 3'd0,
    CMD_UNPIN = 3'd1,
    CMD_DIRTY = 3'd2,
    CMD_FLUSH = 3'd3,
    CMD_CLEAR = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NOT_FND  = 3'd1,
    STS_NO_FREE  = 3'd2,
    STS_NOT_PIN  = 3'd3,
    STS_PIN_OVF  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ACT_NONE  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OP,
    ST_SCAN,
    ST_TAIL,
    ST_FINAL
  } state_e;

  typedef struct packed {
    logic [PinW-1:0] pins;
    logic            dirty;
  } entry_t;

  function automatic logic [IdxOutW-1:0] slot_field(logic [SlotW-1:0] idx);
    logic [SlotW+IdxOutW-1:0] ext;
    ext = {{IdxOutW{1'b0}}, idx};
    return ext[IdxOutW-1:0];
  endfunction

endpackage

// ===== src/page_buffer_pin_manager.sv =====
// Pin and tag bookkeeping for a pool of page slots.
//
// Command channel: present command_i, file_id_i and page_number_i with
// start_i; the command is taken at a clock edge where start_i is high and
// busy_o is low. Results come back on status_o, slot_index_o, action_o,
// action_file_o, action_page_o and last_o, each valid for exactly one cycle
// while valid_o is high; last_o marks the final result of a command.
//
// Pin, unpin and mark dirty: tags are compared against every slot in the
// accept cycle, the pin count and dirty bit of the chosen slot are read from
// the slot memory, updated and written back in the next cycle. The result
// shows from the result register; a new command waits while busy_o is high.
// Flush and clear file sweep the slot memory one slot per cycle, busy until
// the sweep and its final result are done, with up to SLOTS write-back
// results. The sweep is bounded by the single memory read port.
//
// Reset empties the pool (no valid slot, no pins, all clean). The receiver
// cannot stall: each result is taken in the cycle it is shown.
module page_buffer_pin_manager (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic [2:0]                 command_i,
  input  logic [pbpm_pkg::FileW-1:0] file_id_i,
  input  logic [pbpm_pkg::PageW-1:0] page_number_i,
  output logic                       valid_o,
  output logic [2:0]                 status_o,
  output logic [3:0]                 slot_index_o,
  output logic [1:0]                 action_o,
  output logic [pbpm_pkg::FileW-1:0] action_file_o,
  output logic [pbpm_pkg::PageW-1:0] action_page_o,
  output logic                       last_o
);
  import pbpm_pkg::*;

  localparam logic [SlotW-1:0] LastIdx = SlotW'(SLOTS - 1);

  state_e state_q, state_d;

  // command registers
  cmd_e             cmd_q;
  logic [FileW-1:0] file_q;
  logic [PageW-1:0] page_q;
  logic             hit_q, hit_d;
  logic [SlotW-1:0] hit_idx_q, hit_idx_d;
  logic             free_q, free_d;
  logic [SlotW-1:0] free_idx_q, free_idx_d;
  logic [SlotW-1:0] cnt_q, cnt_d;

  // tag store, compared in parallel
  logic [SLOTS-1:0] tag_v_q, tag_v_d;
  logic [FileW-1:0] tag_file_q [SLOTS];
  logic [PageW-1:0] tag_page_q [SLOTS];
  logic             tag_load;
  logic [SlotW-1:0] tag_idx;
  logic [SLOTS-1:0] nz_q, nz_d;       // slot has nonzero pins
  logic [SLOTS-1:0] mem_ok_q, mem_ok_d;

  // slot memory: pin count and dirty bit
  entry_t           mem [SLOTS];
  entry_t           rd_q;
  logic             rd_ok_q;
  logic [SlotW-1:0] rd_idx_q;
  logic             mem_we, mem_re;
  logic [SlotW-1:0] mem_wa, mem_ra;
  entry_t           mem_wd;
  entry_t           cur;

  // pending write-back held until the next one or the end of the sweep
  logic             hold_v_q, hold_v_d;
  logic [SlotW-1:0] hold_slot_q, hold_slot_d;
  logic [PageW-1:0] hold_page_q, hold_page_d;

  // result register
  logic             out_v_q, emit;
  status_e          out_status_q, e_status;
  logic [SlotW-1:0] out_slot_q, e_slot;
  action_e          out_action_q, e_action;
  logic [FileW-1:0] out_file_q, e_file;
  logic [PageW-1:0] out_page_q, e_page;
  logic             out_last_q, e_last;

  logic [SLOTS-1:0] hit_vec, match_file;
  logic             accept, scan_chk, qual;
  logic [PinW-1:0]  pins_dec;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_vec[i]    = tag_v_q[i] && (tag_file_q[i] == file_id_i) &&
                      (tag_page_q[i] == page_number_i);
      match_file[i] = tag_v_q[i] && (tag_file_q[i] == file_q);
    end
  end

  // lowest matching slot and lowest slot with zero pins
  always_comb begin
    hit_d      = 1'b0;
    hit_idx_d  = '0;
    free_d     = 1'b0;
    free_idx_d = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        hit_d     = 1'b1;
        hit_idx_d = SlotW'(i);
      end
      if (!nz_q[i]) begin
        free_d     = 1'b1;
        free_idx_d = SlotW'(i);
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (cmd_e'(command_i) == CMD_FLUSH || cmd_e'(command_i) == CMD_CLEAR) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_OP;
          end
        end
      end
      ST_OP:    state_d = ST_IDLE;
      ST_SCAN:  if (cnt_q == LastIdx) state_d = ST_TAIL;
      ST_TAIL:  state_d = ST_FINAL;
      ST_FINAL: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign cur      = rd_ok_q ? rd_q : '0;
  assign pins_dec = cur.pins - PinW'(1);
  assign scan_chk = (state_q == ST_SCAN && cnt_q != '0) || (state_q == ST_TAIL);
  assign qual     = scan_chk && match_file[rd_idx_q] && cur.dirty;

  // datapath and outputs
  always_comb begin
    mem_re      = 1'b0;
    mem_ra      = cnt_q;
    mem_we      = 1'b0;
    mem_wa      = rd_idx_q;
    mem_wd      = cur;
    cnt_d       = cnt_q;
    tag_v_d     = tag_v_q;
    nz_d        = nz_q;
    mem_ok_d    = mem_ok_q;
    tag_load    = 1'b0;
    tag_idx     = free_idx_q;
    hold_v_d    = hold_v_q;
    hold_slot_d = hold_slot_q;
    hold_page_d = hold_page_q;
    emit        = 1'b0;
    e_status    = STS_OK;
    e_slot      = '0;
    e_action    = ACT_NONE;
    e_file      = '0;
    e_page      = '0;
    e_last      = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          mem_re   = 1'b1;
          mem_ra   = hit_d ? hit_idx_d : free_idx_d;
          cnt_d    = '0;
          hold_v_d = 1'b0;
        end
      end

      ST_OP: begin
        emit = 1'b1;
        unique case (cmd_q)
          CMD_PIN: begin
            if (hit_q) begin
              e_slot = hit_idx_q;
              if (cur.pins == PIN_MAX) begin
                e_status = STS_PIN_OVF;
              end else begin
                mem_we      = 1'b1;
                mem_wd.pins = cur.pins + PinW'(1);
                nz_d[hit_idx_q] = 1'b1;
              end
            end else if (free_q) begin
              mem_we       = 1'b1;
              mem_wa       = free_idx_q;
              mem_wd.pins  = PinW'(1);
              mem_wd.dirty = 1'b0;
              tag_load     = 1'b1;
              tag_v_d[free_idx_q] = 1'b1;
              nz_d[free_idx_q]    = 1'b1;
              e_slot   = free_idx_q;
              e_action = ACT_READ;
              e_file   = file_q;
              e_page   = page_q;
            end else begin
              e_status = STS_NO_FREE;
            end
          end
          CMD_UNPIN: begin
            if (!hit_q) begin
              e_status = STS_NOT_FND;
            end else if (cur.pins == '0) begin
              e_status = STS_NOT_PIN;
              e_slot   = hit_idx_q;
            end else begin
              e_slot      = hit_idx_q;
              mem_we      = 1'b1;
              mem_wd.pins = pins_dec;
              if (pins_dec == '0) begin
                nz_d[hit_idx_q] = 1'b0;
                if (cur.dirty) begin
                  mem_wd.dirty = 1'b0;
                  e_action     = ACT_WRITE;
                  e_file       = file_q;
                  e_page       = page_q;
                end
              end
            end
          end
          CMD_DIRTY: begin
            if (!hit_q) begin
              e_status = STS_NOT_FND;
            end else if (cur.pins == '0) begin
              e_status = STS_NOT_PIN;
              e_slot   = hit_idx_q;
            end else begin
              e_slot       = hit_idx_q;
              mem_we       = 1'b1;
              mem_wd.dirty = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end

      ST_SCAN, ST_TAIL: begin
        if (state_q == ST_SCAN) begin
          mem_re = 1'b1;
          mem_ra = cnt_q;
          cnt_d  = cnt_q + SlotW'(1);
        end
        if (qual) begin
          mem_we       = 1'b1;
          mem_wd.dirty = 1'b0;
          if (cmd_q == CMD_CLEAR) begin
            mem_wd.pins       = '0;
            tag_v_d[rd_idx_q] = 1'b0;
            nz_d[rd_idx_q]    = 1'b0;
          end
          // release the previous write-back, it is not the last one
          if (hold_v_q) begin
            emit     = 1'b1;
            e_slot   = hold_slot_q;
            e_action = ACT_WRITE;
            e_file   = file_q;
            e_page   = hold_page_q;
            e_last   = 1'b0;
          end
          hold_v_d    = 1'b1;
          hold_slot_d = rd_idx_q;
          hold_page_d = tag_page_q[rd_idx_q];
        end
      end

      ST_FINAL: begin
        emit = 1'b1;
        if (hold_v_q) begin
          e_slot   = hold_slot_q;
          e_action = ACT_WRITE;
          e_file   = file_q;
          e_page   = hold_page_q;
        end
        hold_v_d = 1'b0;
      end

      default: begin
      end
    endcase

    if (mem_we) begin
      mem_ok_d[mem_wa] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      tag_v_q  <= '0;
      nz_q     <= '0;
      mem_ok_q <= '0;
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      tag_v_q  <= tag_v_d;
      nz_q     <= nz_d;
      mem_ok_q <= mem_ok_d;
      hold_v_q <= hold_v_d;
      out_v_q  <= emit;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q      <= cmd_e'(command_i);
      file_q     <= file_id_i;
      page_q     <= page_number_i;
      hit_q      <= hit_d;
      hit_idx_q  <= hit_idx_d;
      free_q     <= free_d;
      free_idx_q <= free_idx_d;
    end
    if (tag_load) begin
      tag_file_q[tag_idx] <= file_q;
      tag_page_q[tag_idx] <= page_q;
    end
    hold_slot_q <= hold_slot_d;
    hold_page_q <= hold_page_d;
    if (emit) begin
      out_status_q <= e_status;
      out_slot_q   <= e_slot;
      out_action_q <= e_action;
      out_file_q   <= e_file;
      out_page_q   <= e_page;
      out_last_q   <= e_last;
    end
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q     <= mem[mem_ra];
      rd_ok_q  <= mem_ok_q[mem_ra];
      rd_idx_q <= mem_ra;
    end
  end

  assign valid_o       = out_v_q;
  assign status_o      = out_status_q;
  assign slot_index_o  = slot_field(out_slot_q);
  assign action_o      = out_action_q;
  assign action_file_o = out_file_q;
  assign action_page_o = out_page_q;
  assign last_o        = out_last_q;

endmodule
